/* rtl/core/tcm_pkg.sv */
// ----------------------------------------------------------------------------
// tcm_pkg: shared types, widths and step functions
// Widths of every stage of the triangle circumcircle metrics pipeline, the
// status codes and the single-step functions of the root and divide stages.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W - 1;
  localparam int LEN_W     = SQ_W + 1;
  localparam int DBL_W     = 2 * DIFF_W;
  localparam int AD2_W     = DBL_W;
  localparam int NUM_W     = DIFF_W + LEN_W + 2;
  localparam int T_W       = NUM_W + 1;
  localparam int RT_N_W    = LEN_W + 2 * FRAC_W + 1;
  localparam int SIDE_W    = (LEN_W + 2 * FRAC_W + 1) / 2;
  localparam int RT_STEPS  = SIDE_W;
  localparam int PER_W     = SIDE_W + 2;
  localparam int PL_W      = SIDE_W + FRAC_W;
  localparam int M_W       = 2 * SIDE_W - FRAC_W;
  localparam int MH_W      = M_W / 2;
  localparam int QP_W      = (M_W - MH_W) + SIDE_W;
  localparam int NR_W      = M_W + SIDE_W - FRAC_W;
  localparam int IRV_W     = AD2_W - 1 + 3 * FRAC_W;
  localparam int CV_W      = T_W + FRAC_W;
  localparam int DIV_W     = PER_W;
  localparam int QUO_W     = 64;
  localparam int CTR_W     = 64;
  localparam int RAD_W     = 63;
  localparam int ASP_W     = 16;
  localparam int ASP_STEPS = FRAC_W - 1;
  localparam int IN_W      = 6 * COORD_W;
  localparam int OUT_W     = 248;
  localparam int NSTG      = 7 + RT_STEPS + 4 + QUO_W + 1 + ASP_STEPS + 1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_P01    = 3'd1,
    ST_P12    = 3'd2,
    ST_P20    = 3'd3,
    ST_COLLIN = 3'd4
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DBL_W-1:0]   dbl;
    logic [AD2_W-1:0]          ad2;
    logic [T_W-1:0]            txm;
    logic                      txneg;
    logic [T_W-1:0]            tym;
    logic                      tyneg;
  } meta_t;

  typedef struct packed {
    logic [RT_N_W-1:0] rem;
    logic [RT_N_W-1:0] res;
  } rt_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] dq;
  } dv_t;

  typedef struct packed {
    dv_t                     rad;
    dv_t                     ir;
    dv_t                     cx;
    dv_t                     cy;
    logic [AD2_W-1:0]        ad2;
    logic [PER_W-1:0]        per;
    status_t                 status;
    logic signed [DBL_W-1:0] dbl;
    logic                    txneg;
    logic                    tyneg;
    logic                    ovf_rad;
    logic                    ovf_cx;
    logic                    ovf_cy;
  } dp_t;

  typedef struct packed {
    status_t                 status;
    logic signed [DBL_W-1:0] dbl;
    logic [CTR_W-1:0]        cx;
    logic [CTR_W-1:0]        cy;
    logic [RAD_W-1:0]        rad;
    logic [QUO_W-1:0]        rem;
    logic [ASP_STEPS-1:0]    q;
    logic                    cap;
  } ap_t;

  // one result bit of the floor square root, test weight 4^k
  function automatic rt_t rt_step(rt_t s, int k);
    logic [RT_N_W-1:0] bitv;
    logic [RT_N_W-1:0] t;
    rt_t r;
    bitv = RT_N_W'(1) << (2 * k);
    t    = s.res + bitv;
    if (s.rem >= t) begin
      r.rem = s.rem - t;
      r.res = (s.res >> 1) + bitv;
    end else begin
      r.rem = s.rem;
      r.res = s.res >> 1;
    end
    return r;
  endfunction

  // one quotient bit of a restoring divide, dividend bits shift out of dq
  function automatic dv_t div_step(dv_t s, logic [DIV_W-1:0] d);
    logic [DIV_W:0] trial;
    dv_t r;
    trial = {s.rem, s.dq[QUO_W-1]};
    if (trial >= {1'b0, d}) begin
      r.rem = DIV_W'(trial - {1'b0, d});
      r.dq  = {s.dq[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DIV_W-1:0];
      r.dq  = {s.dq[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // signed centre coordinate from quotient magnitude, saturated
  function automatic logic [CTR_W-1:0] ctr_sat(logic [QUO_W-1:0] q, logic ovf, logic neg);
    logic [CTR_W-1:0] mag;
    logic             big;
    if (neg) begin
      big = ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]));
      mag = big ? {1'b1, {(CTR_W-1){1'b0}}} : CTR_W'(q);
      return CTR_W'(-mag);
    end else begin
      big = ovf || q[QUO_W-1];
      mag = big ? {1'b0, {(CTR_W-1){1'b1}}} : CTR_W'(q);
      return mag;
    end
  endfunction

endpackage

/* rtl/core/triangle_circumcircle_metrics_unit.sv */
// ----------------------------------------------------------------------------
// triangle_circumcircle_metrics_unit: circumcircle and shape metrics
// One triangle per input item (three signed points on in_tdata), one result
// item per triangle on out_tdata: status, circumcentre, circumradius, doubled
// signed area and inradius/circumradius ratio.
// The block is a single pipeline of 125 register stages; it takes one new
// item every cycle unless the output holds. The depth is set by the three
// 33-step side-length roots and the 64-step restoring dividers for centre,
// radius and inradius, then 15 steps for the ratio.
// Valid bits travel with each stage. When the output holds a result that is
// not taken, the whole pipeline holds and in_tready drops; bubbles are filled
// as long as the output stage is free or being emptied.
// Reset clears all valid bits; payload registers are not reset.
// Coincident or collinear points give a non-zero status with centre, radius
// and ratio forced to zero; the doubled area is always exact.
// ----------------------------------------------------------------------------
module triangle_circumcircle_metrics_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // x0, y0, x1, y1, x2, y2, 16 bits each
  input  logic [tcm_pkg::IN_W-1:0]  in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // status, center_x, center_y, radius, doubled_signed_area, aspect_ratio
  output logic [tcm_pkg::OUT_W-1:0] out_tdata
);
  import tcm_pkg::*;

  logic                en;
  logic [NSTG-1:0]     vld_r;

  logic signed [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1, in_x2, in_y2;

  assign in_x0 = $signed(in_tdata[COORD_W-1:0]);
  assign in_y0 = $signed(in_tdata[2*COORD_W-1:COORD_W]);
  assign in_x1 = $signed(in_tdata[3*COORD_W-1:2*COORD_W]);
  assign in_y1 = $signed(in_tdata[4*COORD_W-1:3*COORD_W]);
  assign in_x2 = $signed(in_tdata[5*COORD_W-1:4*COORD_W]);
  assign in_y2 = $signed(in_tdata[6*COORD_W-1:5*COORD_W]);

  assign en         = !vld_r[NSTG-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // ---------------- stage 1: differences, coincidence tests
  logic signed [DIFF_W-1:0]  s1_bx_r, s1_by_r, s1_cx_r, s1_cy_r, s1_ex_r, s1_ey_r;
  logic signed [COORD_W-1:0] s1_x0_r, s1_y0_r;
  logic [2:0]                s1_eq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bx_r <= DIFF_W'(in_x1) - DIFF_W'(in_x0);
      s1_by_r <= DIFF_W'(in_y1) - DIFF_W'(in_y0);
      s1_cx_r <= DIFF_W'(in_x2) - DIFF_W'(in_x0);
      s1_cy_r <= DIFF_W'(in_y2) - DIFF_W'(in_y0);
      s1_ex_r <= DIFF_W'(in_x2) - DIFF_W'(in_x1);
      s1_ey_r <= DIFF_W'(in_y2) - DIFF_W'(in_y1);
      s1_x0_r <= in_x0;
      s1_y0_r <= in_y0;
      s1_eq_r <= {(in_x2 == in_x0) && (in_y2 == in_y0),
                  (in_x1 == in_x2) && (in_y1 == in_y2),
                  (in_x0 == in_x1) && (in_y0 == in_y1)};
    end
  end

  // ---------------- stage 2: cross products and squares
  logic signed [DBL_W-1:0]   s2_pbc_r, s2_pbycx_r;
  logic [SQ_W-1:0]           s2_bx2_r, s2_by2_r, s2_cx2_r, s2_cy2_r, s2_ex2_r, s2_ey2_r;
  logic signed [DIFF_W-1:0]  s2_bx_r, s2_by_r, s2_cx_r, s2_cy_r;
  logic signed [COORD_W-1:0] s2_x0_r, s2_y0_r;
  logic [2:0]                s2_eq_r;
  logic signed [DBL_W-1:0]   s2_pbc_nxt, s2_pbycx_nxt;
  logic signed [DBL_W-1:0]   sq_bx, sq_by, sq_cx, sq_cy, sq_ex, sq_ey;

  always_comb begin
    s2_pbc_nxt   = DBL_W'(s1_bx_r) * DBL_W'(s1_cy_r);
    s2_pbycx_nxt = DBL_W'(s1_by_r) * DBL_W'(s1_cx_r);
    sq_bx        = DBL_W'(s1_bx_r) * DBL_W'(s1_bx_r);
    sq_by        = DBL_W'(s1_by_r) * DBL_W'(s1_by_r);
    sq_cx        = DBL_W'(s1_cx_r) * DBL_W'(s1_cx_r);
    sq_cy        = DBL_W'(s1_cy_r) * DBL_W'(s1_cy_r);
    sq_ex        = DBL_W'(s1_ex_r) * DBL_W'(s1_ex_r);
    sq_ey        = DBL_W'(s1_ey_r) * DBL_W'(s1_ey_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pbc_r   <= s2_pbc_nxt;
      s2_pbycx_r <= s2_pbycx_nxt;
      s2_bx2_r   <= sq_bx[SQ_W-1:0];
      s2_by2_r   <= sq_by[SQ_W-1:0];
      s2_cx2_r   <= sq_cx[SQ_W-1:0];
      s2_cy2_r   <= sq_cy[SQ_W-1:0];
      s2_ex2_r   <= sq_ex[SQ_W-1:0];
      s2_ey2_r   <= sq_ey[SQ_W-1:0];
      s2_bx_r    <= s1_bx_r;
      s2_by_r    <= s1_by_r;
      s2_cx_r    <= s1_cx_r;
      s2_cy_r    <= s1_cy_r;
      s2_x0_r    <= s1_x0_r;
      s2_y0_r    <= s1_y0_r;
      s2_eq_r    <= s1_eq_r;
    end
  end

  // ---------------- stage 3: doubled area, squared lengths, status
  logic signed [DBL_W-1:0]   s3_dbl_r;
  logic [LEN_W-1:0]          s3_l1_r, s3_l2_r, s3_lb_r;
  status_t                   s3_status_r;
  logic signed [DIFF_W-1:0]  s3_bx_r, s3_by_r, s3_cx_r, s3_cy_r;
  logic signed [COORD_W-1:0] s3_x0_r, s3_y0_r;
  logic signed [DBL_W-1:0]   s3_dbl_nxt;
  status_t                   s3_status_nxt;

  always_comb begin
    s3_dbl_nxt = s2_pbc_r - s2_pbycx_r;
    if (s2_eq_r[0]) begin
      s3_status_nxt = ST_P01;
    end else if (s2_eq_r[1]) begin
      s3_status_nxt = ST_P12;
    end else if (s2_eq_r[2]) begin
      s3_status_nxt = ST_P20;
    end else if (s3_dbl_nxt == '0) begin
      s3_status_nxt = ST_COLLIN;
    end else begin
      s3_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dbl_r    <= s3_dbl_nxt;
      s3_status_r <= s3_status_nxt;
      s3_l1_r     <= LEN_W'(s2_bx2_r) + LEN_W'(s2_by2_r);
      s3_l2_r     <= LEN_W'(s2_cx2_r) + LEN_W'(s2_cy2_r);
      s3_lb_r     <= LEN_W'(s2_ex2_r) + LEN_W'(s2_ey2_r);
      s3_bx_r     <= s2_bx_r;
      s3_by_r     <= s2_by_r;
      s3_cx_r     <= s2_cx_r;
      s3_cy_r     <= s2_cy_r;
      s3_x0_r     <= s2_x0_r;
      s3_y0_r     <= s2_y0_r;
    end
  end

  // ---------------- stage 4: numerator products, |2D|
  logic signed [NUM_W-1:0]   s4_cyl1_r, s4_byl2_r, s4_bxl2_r, s4_cxl1_r;
  logic [AD2_W-1:0]          s4_ad2_r;
  logic                      s4_dneg_r;
  logic signed [DBL_W-1:0]   s4_dbl_r;
  status_t                   s4_status_r;
  logic [LEN_W-1:0]          s4_l1_r, s4_l2_r, s4_lb_r;
  logic signed [COORD_W-1:0] s4_x0_r, s4_y0_r;
  logic [DBL_W-1:0]          s4_absd_nxt;

  assign s4_absd_nxt = s3_dbl_r[DBL_W-1] ? DBL_W'(-s3_dbl_r) : DBL_W'(s3_dbl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cyl1_r   <= NUM_W'(s3_cy_r) * NUM_W'($signed({1'b0, s3_l1_r}));
      s4_byl2_r   <= NUM_W'(s3_by_r) * NUM_W'($signed({1'b0, s3_l2_r}));
      s4_bxl2_r   <= NUM_W'(s3_bx_r) * NUM_W'($signed({1'b0, s3_l2_r}));
      s4_cxl1_r   <= NUM_W'(s3_cx_r) * NUM_W'($signed({1'b0, s3_l1_r}));
      s4_ad2_r    <= {s4_absd_nxt[AD2_W-2:0], 1'b0};
      s4_dneg_r   <= s3_dbl_r[DBL_W-1];
      s4_dbl_r    <= s3_dbl_r;
      s4_status_r <= s3_status_r;
      s4_l1_r     <= s3_l1_r;
      s4_l2_r     <= s3_l2_r;
      s4_lb_r     <= s3_lb_r;
      s4_x0_r     <= s3_x0_r;
      s4_y0_r     <= s3_y0_r;
    end
  end

  // ---------------- stage 5: numerators, p0 * |2D|
  logic signed [NUM_W-1:0] s5_nx_r, s5_ny_r;
  logic signed [T_W-1:0]   s5_px_r, s5_py_r;
  logic [AD2_W-1:0]        s5_ad2_r;
  logic                    s5_dneg_r;
  logic signed [DBL_W-1:0] s5_dbl_r;
  status_t                 s5_status_r;
  logic [LEN_W-1:0]        s5_l1_r, s5_l2_r, s5_lb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_nx_r     <= s4_cyl1_r - s4_byl2_r;
      s5_ny_r     <= s4_bxl2_r - s4_cxl1_r;
      s5_px_r     <= T_W'(s4_x0_r) * T_W'($signed({1'b0, s4_ad2_r}));
      s5_py_r     <= T_W'(s4_y0_r) * T_W'($signed({1'b0, s4_ad2_r}));
      s5_ad2_r    <= s4_ad2_r;
      s5_dneg_r   <= s4_dneg_r;
      s5_dbl_r    <= s4_dbl_r;
      s5_status_r <= s4_status_r;
      s5_l1_r     <= s4_l1_r;
      s5_l2_r     <= s4_l2_r;
      s5_lb_r     <= s4_lb_r;
    end
  end

  // ---------------- stage 6: centre numerator over |2D|
  logic signed [T_W-1:0]   s6_tx_r, s6_ty_r;
  logic [AD2_W-1:0]        s6_ad2_r;
  logic signed [DBL_W-1:0] s6_dbl_r;
  status_t                 s6_status_r;
  logic [LEN_W-1:0]        s6_l1_r, s6_l2_r, s6_lb_r;
  logic signed [T_W-1:0]   nx_ext, ny_ext;

  assign nx_ext = T_W'(s5_nx_r);
  assign ny_ext = T_W'(s5_ny_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tx_r     <= s5_px_r + (s5_dneg_r ? -nx_ext : nx_ext);
      s6_ty_r     <= s5_py_r + (s5_dneg_r ? -ny_ext : ny_ext);
      s6_ad2_r    <= s5_ad2_r;
      s6_dbl_r    <= s5_dbl_r;
      s6_status_r <= s5_status_r;
      s6_l1_r     <= s5_l1_r;
      s6_l2_r     <= s5_l2_r;
      s6_lb_r     <= s5_lb_r;
    end
  end

  // ---------------- stage 7: magnitudes and signs
  meta_t            s7_meta_r;
  logic [LEN_W-1:0] s7_l1_r, s7_l2_r, s7_lb_r;
  meta_t            s7_meta_nxt;

  always_comb begin
    s7_meta_nxt.status = s6_status_r;
    s7_meta_nxt.dbl    = s6_dbl_r;
    s7_meta_nxt.ad2    = s6_ad2_r;
    s7_meta_nxt.txneg  = s6_tx_r[T_W-1];
    s7_meta_nxt.txm    = s6_tx_r[T_W-1] ? T_W'(-s6_tx_r) : T_W'(s6_tx_r);
    s7_meta_nxt.tyneg  = s6_ty_r[T_W-1];
    s7_meta_nxt.tym    = s6_ty_r[T_W-1] ? T_W'(-s6_ty_r) : T_W'(s6_ty_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_meta_r <= s7_meta_nxt;
      s7_l1_r   <= s6_l1_r;
      s7_l2_r   <= s6_l2_r;
      s7_lb_r   <= s6_lb_r;
    end
  end

  // ---------------- side lengths: one root bit per stage
  rt_t   rta_r [RT_STEPS];
  rt_t   rtb_r [RT_STEPS];
  rt_t   rtc_r [RT_STEPS];
  meta_t rtm_r [RT_STEPS];

  for (genvar i = 0; i < RT_STEPS; i++) begin : g_rt
    rt_t   a_in, b_in, c_in;
    meta_t m_in;
    if (i == 0) begin : g_first
      assign a_in = '{rem: RT_N_W'({s7_l1_r, {(2*FRAC_W){1'b0}}}), res: '0};
      assign b_in = '{rem: RT_N_W'({s7_lb_r, {(2*FRAC_W){1'b0}}}), res: '0};
      assign c_in = '{rem: RT_N_W'({s7_l2_r, {(2*FRAC_W){1'b0}}}), res: '0};
      assign m_in = s7_meta_r;
    end else begin : g_next
      assign a_in = rta_r[i-1];
      assign b_in = rtb_r[i-1];
      assign c_in = rtc_r[i-1];
      assign m_in = rtm_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rta_r[i] <= rt_step(a_in, RT_STEPS - 1 - i);
        rtb_r[i] <= rt_step(b_in, RT_STEPS - 1 - i);
        rtc_r[i] <= rt_step(c_in, RT_STEPS - 1 - i);
        rtm_r[i] <= m_in;
      end
    end
  end

  logic [SIDE_W-1:0] side_a, side_b, side_c;

  assign side_a = rta_r[RT_STEPS-1].res[SIDE_W-1:0];
  assign side_b = rtb_r[RT_STEPS-1].res[SIDE_W-1:0];
  assign side_c = rtc_r[RT_STEPS-1].res[SIDE_W-1:0];

  // ---------------- a*b then (ab >> F) * c, split into narrow products
  logic [PL_W-1:0]   mu1_plo_r;
  logic [M_W-1:0]    mu1_phi_r;
  logic [SIDE_W-1:0] mu1_c_r, mu2_c_r;
  logic [PER_W-1:0]  mu1_per_r, mu2_per_r, mu3_per_r, mu4_per_r;
  meta_t             mu1_meta_r, mu2_meta_r, mu3_meta_r, mu4_meta_r;
  logic [M_W-1:0]    mu2_m_r;
  logic [QP_W-1:0]   mu3_ql_r, mu3_qh_r;
  logic [NR_W-1:0]   mu4_nr_r;
  logic [2*SIDE_W-1:0] mu2_ab_nxt;
  logic [M_W+SIDE_W-1:0] mu4_mc_nxt;

  assign mu2_ab_nxt = (2*SIDE_W)'(mu1_plo_r) + {mu1_phi_r, {FRAC_W{1'b0}}};
  assign mu4_mc_nxt = (M_W+SIDE_W)'(mu3_ql_r) + {mu3_qh_r, {MH_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      mu1_plo_r  <= PL_W'(side_a) * PL_W'(side_b[FRAC_W-1:0]);
      mu1_phi_r  <= M_W'(side_a) * M_W'(side_b[SIDE_W-1:FRAC_W]);
      mu1_c_r    <= side_c;
      mu1_per_r  <= PER_W'(side_a) + PER_W'(side_b) + PER_W'(side_c);
      mu1_meta_r <= rtm_r[RT_STEPS-1];

      mu2_m_r    <= mu2_ab_nxt[2*SIDE_W-1:FRAC_W];
      mu2_c_r    <= mu1_c_r;
      mu2_per_r  <= mu1_per_r;
      mu2_meta_r <= mu1_meta_r;

      mu3_ql_r   <= QP_W'(mu2_m_r[MH_W-1:0]) * QP_W'(mu2_c_r);
      mu3_qh_r   <= QP_W'(mu2_m_r[M_W-1:MH_W]) * QP_W'(mu2_c_r);
      mu3_per_r  <= mu2_per_r;
      mu3_meta_r <= mu2_meta_r;

      mu4_nr_r   <= mu4_mc_nxt[M_W+SIDE_W-1:FRAC_W];
      mu4_per_r  <= mu3_per_r;
      mu4_meta_r <= mu3_meta_r;
    end
  end

  // ---------------- divider set-up
  dp_t                 dv_in;
  logic [AD2_W-2:0]    absd;
  logic [IRV_W-1:0]    irv;
  logic [CV_W-1:0]     cxv, cyv;
  logic [DIV_W-1:0]    ad2_ext;

  always_comb begin
    absd    = mu4_meta_r.ad2[AD2_W-1:1];
    irv     = {absd, {(3*FRAC_W){1'b0}}};
    cxv     = {mu4_meta_r.txm, {FRAC_W{1'b0}}};
    cyv     = {mu4_meta_r.tym, {FRAC_W{1'b0}}};
    ad2_ext = DIV_W'(mu4_meta_r.ad2);

    dv_in.rad.rem = DIV_W'(mu4_nr_r[NR_W-1:QUO_W]);
    dv_in.rad.dq  = mu4_nr_r[QUO_W-1:0];
    dv_in.ir.rem  = DIV_W'(irv[IRV_W-1:QUO_W]);
    dv_in.ir.dq   = irv[QUO_W-1:0];
    dv_in.cx.rem  = DIV_W'(cxv[CV_W-1:QUO_W]);
    dv_in.cx.dq   = cxv[QUO_W-1:0];
    dv_in.cy.rem  = DIV_W'(cyv[CV_W-1:QUO_W]);
    dv_in.cy.dq   = cyv[QUO_W-1:0];
    dv_in.ad2     = mu4_meta_r.ad2;
    dv_in.per     = mu4_per_r;
    dv_in.status  = mu4_meta_r.status;
    dv_in.dbl     = mu4_meta_r.dbl;
    dv_in.txneg   = mu4_meta_r.txneg;
    dv_in.tyneg   = mu4_meta_r.tyneg;
    // quotient would not fit in 64 bits
    dv_in.ovf_rad = DIV_W'(mu4_nr_r[NR_W-1:QUO_W]) >= ad2_ext;
    dv_in.ovf_cx  = DIV_W'(cxv[CV_W-1:QUO_W]) >= ad2_ext;
    dv_in.ovf_cy  = DIV_W'(cyv[CV_W-1:QUO_W]) >= ad2_ext;
  end

  // ---------------- four dividers, one quotient bit per stage
  dp_t dp_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    dp_t d_in;
    dp_t d_nxt;
    if (k == 0) begin : g_first
      assign d_in = dv_in;
    end else begin : g_next
      assign d_in = dp_r[k-1];
    end
    always_comb begin
      d_nxt     = d_in;
      d_nxt.rad = div_step(d_in.rad, DIV_W'(d_in.ad2));
      d_nxt.cx  = div_step(d_in.cx, DIV_W'(d_in.ad2));
      d_nxt.cy  = div_step(d_in.cy, DIV_W'(d_in.ad2));
      d_nxt.ir  = div_step(d_in.ir, d_in.per);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dp_r[k] <= d_nxt;
      end
    end
  end

  // ---------------- saturation, ratio set-up
  ap_t                        ap_r [ASP_STEPS+1];
  ap_t                        ap0_nxt;
  logic [QUO_W-1:0]           rad_q;
  logic [RAD_W+ASP_STEPS-1:0] rad_sh;

  always_comb begin
    rad_q          = dp_r[QUO_W-1].rad.dq;
    ap0_nxt.status = dp_r[QUO_W-1].status;
    ap0_nxt.dbl    = dp_r[QUO_W-1].dbl;
    ap0_nxt.rad    = (dp_r[QUO_W-1].ovf_rad || rad_q[QUO_W-1]) ? {RAD_W{1'b1}}
                                                               : rad_q[RAD_W-1:0];
    ap0_nxt.cx     = ctr_sat(dp_r[QUO_W-1].cx.dq, dp_r[QUO_W-1].ovf_cx,
                             dp_r[QUO_W-1].txneg);
    ap0_nxt.cy     = ctr_sat(dp_r[QUO_W-1].cy.dq, dp_r[QUO_W-1].ovf_cy,
                             dp_r[QUO_W-1].tyneg);
    ap0_nxt.rem    = dp_r[QUO_W-1].ir.dq;
    ap0_nxt.q      = '0;
    rad_sh         = {ap0_nxt.rad, {ASP_STEPS{1'b0}}};
    // ratio would reach the cap of one half
    ap0_nxt.cap    = (ap0_nxt.rad == '0) ||
                     ((RAD_W+ASP_STEPS)'(ap0_nxt.rem) >= rad_sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap_r[0] <= ap0_nxt;
    end
  end

  for (genvar j = 0; j < ASP_STEPS; j++) begin : g_asp
    ap_t                        a_nxt;
    logic [RAD_W+ASP_STEPS-1:0] sh;
    always_comb begin
      a_nxt = ap_r[j];
      sh    = (RAD_W+ASP_STEPS)'(ap_r[j].rad) << (ASP_STEPS - 1 - j);
      if ((RAD_W+ASP_STEPS)'(ap_r[j].rem) >= sh) begin
        a_nxt.rem                   = ap_r[j].rem - sh[QUO_W-1:0];
        a_nxt.q[ASP_STEPS - 1 - j]  = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ap_r[j+1] <= a_nxt;
      end
    end
  end

  // ---------------- output register
  logic [OUT_W-1:0] out_r;
  logic [OUT_W-1:0] out_nxt;
  logic [ASP_W-1:0] asp_v;
  logic             ok;

  always_comb begin
    ok      = (ap_r[ASP_STEPS].status == ST_OK);
    asp_v   = ap_r[ASP_STEPS].cap ? ASP_W'(1 << (FRAC_W - 1))
                                  : ASP_W'(ap_r[ASP_STEPS].q);
    out_nxt = {{(OUT_W-3-2*CTR_W-RAD_W-DBL_W-ASP_W){1'b0}},
               ok ? asp_v : {ASP_W{1'b0}},
               ap_r[ASP_STEPS].dbl,
               ok ? ap_r[ASP_STEPS].rad : {RAD_W{1'b0}},
               ok ? ap_r[ASP_STEPS].cy : {CTR_W{1'b0}},
               ok ? ap_r[ASP_STEPS].cx : {CTR_W{1'b0}},
               ap_r[ASP_STEPS].status};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

/* dv/triangle_circumcircle_metrics_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_metrics_unit_tb: self-checking bench
// Streams triangles into the unit, works out status, circumcentre, radius,
// doubled area and aspect ratio for each accepted item with wide integer
// arithmetic, and checks every result item in order under random idling and stalls.
// ----------------------------------------------------------------------------
module triangle_circumcircle_metrics_unit_tb;
  import tcm_pkg::*;

  typedef struct packed {
    logic [15:0]        aspect;
    logic signed [33:0] area2;
    logic [62:0]        radius;
    logic [63:0]        cy;
    logic [63:0]        cx;
    status_t            status;
  } metrics_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_W-1:0]         in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_W-1:0]        out_tdata;

  metrics_t metrics_q[$];
  int       n_mismatch;
  int       idle_pct;
  int       stall_pct;
  int       quiet_cycles;

  triangle_circumcircle_metrics_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // p0 + num/d in Q.16, truncated toward zero and saturated
  function automatic logic [63:0] centre_coord(longint p0, logic signed [127:0] num,
                                               longint d);
    logic signed [127:0] t;
    logic [127:0]        ad;
    logic [127:0]        mag;
    logic [127:0]        q;
    ad  = (d < 0) ? 128'(-d) : 128'(d);
    t   = 128'(p0) * $signed(ad) + ((d < 0) ? -num : num);
    mag = (t < 0) ? 128'(-t) : 128'(t);
    q   = (mag << 16) / ad;
    if (t < 0) begin
      if (q > (128'd1 << 63)) q = 128'd1 << 63;
      return 64'(-q);
    end
    if (q > ((128'd1 << 63) - 1)) q = (128'd1 << 63) - 1;
    return q[63:0];
  endfunction

  function automatic metrics_t triangle_metrics(logic [IN_W-1:0] d);
    longint              x0, y0, x1, y1, x2, y2, bx, by, cx, cy, dbl, l1, l2, lb;
    logic signed [127:0] nx, ny;
    logic [127:0]        a, b, c, ad, m, rad, ir, asp;
    metrics_t            r;
    x0  = longint'($signed(d[15:0]));
    y0  = longint'($signed(d[31:16]));
    x1  = longint'($signed(d[47:32]));
    y1  = longint'($signed(d[63:48]));
    x2  = longint'($signed(d[79:64]));
    y2  = longint'($signed(d[95:80]));
    bx  = x1 - x0;
    by  = y1 - y0;
    cx  = x2 - x0;
    cy  = y2 - y0;
    dbl = bx * cy - by * cx;
    r        = '0;
    r.area2  = 34'(dbl);
    if (x0 == x1 && y0 == y1) r.status = ST_P01;
    else if (x1 == x2 && y1 == y2) r.status = ST_P12;
    else if (x2 == x0 && y2 == y0) r.status = ST_P20;
    else if (dbl == 0) r.status = ST_COLLIN;
    else r.status = ST_OK;
    if (r.status != ST_OK) return r;
    l1  = bx * bx + by * by;
    l2  = cx * cx + cy * cy;
    lb  = (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
    a   = floor_sqrt(128'(l1) << 32);
    b   = floor_sqrt(128'(lb) << 32);
    c   = floor_sqrt(128'(l2) << 32);
    ad  = (dbl < 0) ? 128'(-dbl) : 128'(dbl);
    nx  = 128'(cy) * 128'(l1) - 128'(by) * 128'(l2);
    ny  = 128'(bx) * 128'(l2) - 128'(cx) * 128'(l1);
    r.cx = centre_coord(x0, nx, 2 * dbl);
    r.cy = centre_coord(y0, ny, 2 * dbl);
    m   = (a * b) >> 16;
    rad = (m * c) / ((2 * ad) << 16);
    if (rad > ((128'd1 << 63) - 1)) rad = (128'd1 << 63) - 1;
    ir  = (ad << 48) / (a + b + c);
    asp = (rad == 0) ? 128'd32768 : ir / rad;
    if (asp > 128'd32768) asp = 128'd32768;
    r.radius = rad[62:0];
    r.aspect = asp[15:0];
    return r;
  endfunction

  task automatic send_triangle(logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                               logic [15:0] y1, logic [15:0] x2, logic [15:0] y2);
    logic [IN_W-1:0] d;
    d = {y2, x2, y1, x1, y0, x0};
    // each idle cycle is drawn on its own
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    metrics_q.push_back(triangle_metrics(d));
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (metrics_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_triangle;
    int          kind;
    logic [15:0] px, py, vx, vy;
    int          i, j;
    kind = $urandom_range(99);
    px   = 16'($urandom);
    py   = 16'($urandom);
    if (kind < 45) begin
      send_triangle(px, py, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (kind < 75) begin
      // small triangle around a random spot, no wrap
      px = 16'($signed($urandom_range(0, 60000)) - 30000);
      py = 16'($signed($urandom_range(0, 60000)) - 30000);
      send_triangle(px, py, px + 16'($urandom_range(0, 40)) - 16'd20,
                    py + 16'($urandom_range(0, 40)) - 16'd20,
                    px + 16'($urandom_range(0, 40)) - 16'd20,
                    py + 16'($urandom_range(0, 40)) - 16'd20);
    end else if (kind < 87) begin
      px = 16'($urandom_range(0, 2000)) - 16'd1000;
      py = 16'($urandom_range(0, 2000)) - 16'd1000;
      vx = 16'($urandom_range(0, 200)) - 16'd100;
      vy = 16'($urandom_range(0, 200)) - 16'd100;
      i  = $urandom_range(1, 100);
      j  = $urandom_range(1, 100);
      send_triangle(px, py, px + 16'(i) * vx, py + 16'(i) * vy,
                    px - 16'(j) * vx, py - 16'(j) * vy);
    end else begin
      vx = 16'($urandom);
      vy = 16'($urandom);
      case ($urandom_range(2))
        0: send_triangle(px, py, px, py, vx, vy);
        1: send_triangle(vx, vy, px, py, px, py);
        default: send_triangle(px, py, vx, vy, px, py);
      endcase
    end
  endtask

  task automatic test_directed;
    send_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    send_triangle(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    send_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_triangle(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_triangle(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_triangle(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
    // coincident pairs, all three orders, and all three coincident
    send_triangle(16'd5, 16'd7, 16'd5, 16'd7, 16'd9, 16'd1);
    send_triangle(16'd9, 16'd1, 16'd5, 16'd7, 16'd5, 16'd7);
    send_triangle(16'd5, 16'd7, 16'd9, 16'd1, 16'd5, 16'd7);
    send_triangle(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    // collinear
    send_triangle(16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd2);
    send_triangle(16'h8000, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0);
    send_triangle(16'd3, 16'h8000, 16'd3, 16'h7fff, 16'd3, 16'd100);
    // near equilateral, thin needle, huge circumcircle
    send_triangle(16'd0, 16'd0, 16'd1000, 16'd0, 16'd500, 16'd866);
    send_triangle(16'd0, 16'd0, 16'd2, 16'd1, 16'd4, 16'd3);
    send_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h7fff);
    send_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h7ffe, 16'h7fff, 16'h7fff);
    send_triangle(16'h8000, 16'h8001, 16'h7fff, 16'h7fff, 16'h8001, 16'h8000);
    send_triangle(16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
  endtask

  task automatic test_random(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_triangle();
  endtask

  task automatic test_pause_until_empty;
    repeat (20) random_triangle();
    drain();
    repeat (20) random_triangle();
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    metrics_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = metrics_t'(out_tdata[$bits(metrics_t)-1:0]);
      if (metrics_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result item %h", got);
      end else begin
        want = metrics_q.pop_front();
        if (got.status !== want.status || got.cx !== want.cx || got.cy !== want.cy ||
            got.radius !== want.radius || got.area2 !== want.area2 ||
            got.aspect !== want.aspect) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch: status %0d/%0d cx %h/%h cy %h/%h", want.status,
                     got.status, want.cx, got.cx, want.cy, got.cy);
            $display("  radius %h/%h area %0d/%0d aspect %h/%h", want.radius,
                     got.radius, want.area2, got.area2, want.aspect, got.aspect);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n_mismatch   = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(170, 0, 0);
    test_random(170, 71, 0);
    test_random(170, 0, 71);
    test_random(150, 25, 25);
    test_pause_until_empty();
    drain();
    repeat (300) @(posedge clk);
    if (n_mismatch == 0 && metrics_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
